// ===== rtl/core/lom_pkg.sv =====
package lom_pkg;

  localparam int unsigned PRICE_MAX = 1000000;

  typedef enum logic [2:0] {
    KIND_TRADE     = 3'd0,
    KIND_ADDED     = 3'd1,
    KIND_INVALID   = 3'd2,
    KIND_FULL_DUP  = 3'd3,
    KIND_CANCELLED = 3'd4,
    KIND_NOT_FOUND = 3'd5
  } kind_t;

  typedef struct packed {
    logic        cmd;
    logic [31:0] ord_ref;
    logic        is_buy;
    logic        is_market;
    logic [19:0] price;
    logic [30:0] quantity;
    logic [31:0] timestamp;
    logic [31:0] user_id;
  } req_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] fill_seq;
    logic [31:0] bid_ref;
    logic [31:0] ask_ref;
    logic [31:0] bid_user;
    logic [31:0] ask_user;
    logic [19:0] trade_price;
    logic [30:0] trade_qty;
    logic        last;
  } rsp_t;

  typedef struct packed {
    logic cmd_cancel;
    logic bad;
  } cls_t;

  typedef struct packed {
    req_t req;
    cls_t cls;
  } qent_t;

  localparam int QENT_W = $bits(qent_t);

endpackage

// ===== rtl/core/lom_front.sv =====
module lom_front (
  input  logic          start,
  output logic          busy,
  input  lom_pkg::req_t in_req,
  output logic          q_push,
  output lom_pkg::qent_t q_data,
  input  logic          q_full
);
  import lom_pkg::*;

  assign busy   = q_full;
  assign q_push = start && !q_full;

  always_comb begin
    q_data.req            = in_req;
    q_data.cls.cmd_cancel = in_req.cmd;
    q_data.cls.bad        = (in_req.quantity == '0) || (in_req.price == '0) ||
                            ({12'd0, in_req.price} > PRICE_MAX) ||
                            (in_req.ord_ref == '0);
  end

endmodule

// ===== rtl/core/lom_queue.sv =====
module lom_queue #(
  parameter int DEPTH = 2
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  lom_pkg::qent_t  push_data,
  output logic            full,
  input  logic            pop,
  output logic            not_empty,
  output lom_pkg::qent_t  pop_data
);
  import lom_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  qent_t          mem_r [DEPTH];
  logic [AW-1:0]  wp_r, rp_r;
  logic [AW:0]    cnt_r;

  assign full      = (cnt_r == (AW+1)'(DEPTH));
  assign not_empty = (cnt_r != '0);
  assign pop_data  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (wp_r == AW'(DEPTH-1)) ? '0 : wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= (rp_r == AW'(DEPTH-1)) ? '0 : rp_r + 1'b1;
      end
      cnt_r <= cnt_r + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

endmodule

// ===== rtl/core/lom_back.sv =====
module lom_back #(
  parameter int SIDE_DEPTH = 32
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  input  lom_pkg::qent_t q_data,
  output logic           q_pop,
  output logic           out_valid,
  output lom_pkg::rsp_t  out_rsp,
  output logic           idle
);
  import lom_pkg::*;

  localparam int IW = (SIDE_DEPTH > 1) ? $clog2(SIDE_DEPTH) : 1;
  localparam int CW = $clog2(SIDE_DEPTH + 1);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_LOOK   = 7'b0000010,
    S_DECIDE = 7'b0000100,
    S_SCAN   = 7'b0001000,
    S_TRADE  = 7'b0010000,
    S_UPDATE = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_t;

  typedef struct packed {
    logic [31:0] oid;
    logic [31:0] uid;
    logic [19:0] price;
    logic [30:0] qty;
    logic        mkt;
    logic [31:0] ts;
  } ent_t;

  state_t      state_r;
  logic [SIDE_DEPTH-1:0] bv_r, av_r;
  ent_t        bid_r [SIDE_DEPTH];
  ent_t        ask_r [SIDE_DEPTH];
  logic [31:0] tcnt_r;
  qent_t       cur_r;
  logic [CW-1:0] idx_r;
  logic        bhit_r, ahit_r, bfree_r, afree_r;
  logic [IW-1:0] bhit_i_r, ahit_i_r, bfree_i_r, afree_i_r;
  logic        bb_ok_r, ba_ok_r;
  logic [IW-1:0] bb_r, ba_r;
  logic        ov_r;
  rsp_t        orsp_r;
  logic [30:0] mq_r;

  logic [IW-1:0] ci;
  ent_t        be, ae, cb, ca;
  logic        b_ahead, a_ahead;

  assign ci  = idx_r[IW-1:0];
  assign be  = bid_r[ci];
  assign ae  = ask_r[ci];
  assign cb  = bid_r[bb_r];
  assign ca  = ask_r[ba_r];

  always_comb begin
    if (be.price != cb.price)   b_ahead = be.price > cb.price;
    else if (be.ts != cb.ts)    b_ahead = be.ts < cb.ts;
    else                        b_ahead = be.oid < cb.oid;
    if (ae.price != ca.price)   a_ahead = ae.price < ca.price;
    else if (ae.ts != ca.ts)    a_ahead = ae.ts < ca.ts;
    else                        a_ahead = ae.oid < ca.oid;
  end

  assign q_pop     = (state_r == S_IDLE) && q_valid;
  assign out_valid = ov_r;
  assign out_rsp   = orsp_r;
  assign idle      = (state_r == S_IDLE) && !ov_r;

  function automatic rsp_t status(input kind_t k);
    rsp_t r;
    r      = '0;
    r.kind = k;
    r.last = 1'b1;
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (state_r == S_DECIDE && !cur_r.cls.cmd_cancel && !cur_r.cls.bad &&
        !bhit_r && !ahit_r) begin
      if (cur_r.req.is_buy && bfree_r) begin
        bid_r[bfree_i_r] <= '{cur_r.req.ord_ref, cur_r.req.user_id, cur_r.req.price,
                              cur_r.req.quantity, cur_r.req.is_market,
                              cur_r.req.timestamp};
      end
      if (!cur_r.req.is_buy && afree_r) begin
        ask_r[afree_i_r] <= '{cur_r.req.ord_ref, cur_r.req.user_id, cur_r.req.price,
                              cur_r.req.quantity, cur_r.req.is_market,
                              cur_r.req.timestamp};
      end
    end
    if (state_r == S_UPDATE) begin
      bid_r[bb_r].qty <= cb.qty - mq_r;
      ask_r[ba_r].qty <= ca.qty - mq_r;
    end
    if (q_pop) begin
      cur_r <= q_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      bv_r    <= '0;
      av_r    <= '0;
      tcnt_r  <= '0;
      ov_r    <= 1'b0;
      idx_r   <= '0;
      bhit_r  <= 1'b0;
      ahit_r  <= 1'b0;
      bfree_r <= 1'b0;
      afree_r <= 1'b0;
      bb_ok_r <= 1'b0;
      ba_ok_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          ov_r <= 1'b0;
          if (q_valid) begin
            idx_r   <= '0;
            bhit_r  <= 1'b0;
            ahit_r  <= 1'b0;
            bfree_r <= 1'b0;
            afree_r <= 1'b0;
            state_r <= S_LOOK;
          end
        end
        S_LOOK: begin
          ov_r <= 1'b0;
          if (bv_r[ci] && be.oid == cur_r.req.ord_ref && !bhit_r) begin
            bhit_r <= 1'b1; bhit_i_r <= ci;
          end
          if (av_r[ci] && ae.oid == cur_r.req.ord_ref && !ahit_r) begin
            ahit_r <= 1'b1; ahit_i_r <= ci;
          end
          if (!bv_r[ci] && !bfree_r) begin
            bfree_r <= 1'b1; bfree_i_r <= ci;
          end
          if (!av_r[ci] && !afree_r) begin
            afree_r <= 1'b1; afree_i_r <= ci;
          end
          if (idx_r == CW'(SIDE_DEPTH - 1)) state_r <= S_DECIDE;
          else idx_r <= idx_r + 1'b1;
        end
        S_DECIDE: begin
          if (cur_r.cls.cmd_cancel) begin
            ov_r    <= 1'b1;
            state_r <= S_DONE;
            if (bhit_r) begin
              bv_r[bhit_i_r] <= 1'b0;
              orsp_r <= status(KIND_CANCELLED);
            end else if (ahit_r) begin
              av_r[ahit_i_r] <= 1'b0;
              orsp_r <= status(KIND_CANCELLED);
            end else begin
              orsp_r <= status(KIND_NOT_FOUND);
            end
          end else if (cur_r.cls.bad) begin
            ov_r    <= 1'b1;
            state_r <= S_DONE;
            orsp_r  <= status(KIND_INVALID);
          end else if (bhit_r || ahit_r ||
                       (cur_r.req.is_buy ? !bfree_r : !afree_r)) begin
            ov_r    <= 1'b1;
            state_r <= S_DONE;
            orsp_r  <= status(KIND_FULL_DUP);
          end else begin
            if (cur_r.req.is_buy) bv_r[bfree_i_r] <= 1'b1;
            else                  av_r[afree_i_r] <= 1'b1;
            ov_r        <= 1'b0;
            orsp_r      <= status(KIND_ADDED);
            idx_r       <= '0;
            bb_ok_r     <= 1'b0;
            ba_ok_r     <= 1'b0;
            state_r     <= S_SCAN;
          end
        end
        S_SCAN: begin
          ov_r <= 1'b0;
          if (bv_r[ci] && (!bb_ok_r || b_ahead)) begin
            bb_ok_r <= 1'b1; bb_r <= ci;
          end
          if (av_r[ci] && (!ba_ok_r || a_ahead)) begin
            ba_ok_r <= 1'b1; ba_r <= ci;
          end
          if (idx_r == CW'(SIDE_DEPTH - 1)) state_r <= S_TRADE;
          else idx_r <= idx_r + 1'b1;
        end
        S_TRADE: begin
          ov_r <= 1'b1;
          if (bb_ok_r && ba_ok_r && cb.price >= ca.price) begin
            orsp_r.last <= 1'b0;
            mq_r        <= (cb.qty < ca.qty) ? cb.qty : ca.qty;
            state_r     <= S_UPDATE;
          end else begin
            orsp_r.last <= 1'b1;
            state_r     <= S_DONE;
          end
        end
        S_UPDATE: begin
          ov_r   <= 1'b0;
          tcnt_r <= tcnt_r + 1'b1;
          orsp_r <= '{KIND_TRADE, tcnt_r + 1'b1, cb.oid, ca.oid, cb.uid, ca.uid,
                      cb.mkt ? ca.price : cb.price, mq_r, 1'b0};
          if (cb.qty == mq_r) bv_r[bb_r] <= 1'b0;
          if (ca.qty == mq_r) av_r[ba_r] <= 1'b0;
          idx_r   <= '0;
          bb_ok_r <= 1'b0;
          ba_ok_r <= 1'b0;
          state_r <= S_SCAN;
        end
        S_DONE: begin
          ov_r    <= 1'b0;
          state_r <= S_IDLE;
        end
        default: begin
          ov_r    <= 1'b0;
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/limit_order_matcher_top.sv =====
// channel | ports                       | handshake
// request | start, busy, in_req         | taken when start && !busy
// result  | out_valid, out_rsp          | one-cycle strobe per result, receiver cannot stall
//
// The back end handles a cancel or a rejected add with a lookup pass over both tables, then
// decide and done. An accepted add adds a best-entry scan and a trade check; each trade
// adds an update, a new scan and a new trade check.
// Each result strobes for one cycle; the last of a request has last=1.
// Reset clears all valid bits and the trade counter.
// busy is high only while the two-entry request queue is full; results never wait.
module limit_order_matcher_top #(
  parameter int SIDE_DEPTH = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  lom_pkg::req_t in_req,
  output logic          out_valid,
  output lom_pkg::rsp_t out_rsp
);
  import lom_pkg::*;

  logic  q_push, q_full, q_pop, q_ne, bk_idle;
  qent_t q_in, q_out;
  rsp_t  rsp;
  logic  ov;

  lom_front u_front (
    .start, .busy, .in_req,
    .q_push, .q_data(q_in), .q_full
  );

  lom_queue #(.DEPTH(2)) u_queue (
    .clk, .rst_n, .push(q_push), .push_data(q_in), .full(q_full),
    .pop(q_pop), .not_empty(q_ne), .pop_data(q_out)
  );

  lom_back #(.SIDE_DEPTH(SIDE_DEPTH)) u_back (
    .clk, .rst_n, .q_valid(q_ne), .q_data(q_out), .q_pop,
    .out_valid(ov), .out_rsp(rsp), .idle(bk_idle)
  );

  assign out_valid = ov;
  assign out_rsp   = rsp;

  a_pop_has_data: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_ne) else $error("pop from empty queue");
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !q_push) else $error("push into full queue");
  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_rsp.kind <= KIND_NOT_FOUND))
    else $error("result kind out of range");
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    bk_idle |-> !out_valid) else $error("result while idle");

endmodule
